// ===== hdl/tle_pkg.sv =====
// Shared types and constants for the terminal line editor.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package tle_pkg;

    localparam int LINE_MAX   = 64;
    localparam int CUR_W      = $clog2(LINE_MAX + 1);
    localparam int ADDR_W     = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int CHAR_W     = 7;
    localparam int CNT_OUT_W  = 7;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam logic [7:0] ERASE_RESET  = 8'd127;
    localparam logic [7:0] KILL_RESET   = 8'd21;
    localparam logic [7:0] WERASE_RESET = 8'd23;
    localparam logic [7:0] END_RESET    = 8'd4;

    localparam logic [7:0]        PRINT_LOW  = 8'd32;
    localparam logic [7:0]        PRINT_HIGH = 8'd126;
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'd32;

    typedef enum logic [1:0] {
        CFG_ERASE  = 2'd0,
        CFG_KILL   = 2'd1,
        CFG_WERASE = 2'd2,
        CFG_END    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_ECHO  = 2'd0,
        ACT_BELL  = 2'd1,
        ACT_ERASE = 2'd2,
        ACT_END   = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        CMD_ERASE,
        CMD_KILL,
        CMD_WERASE,
        CMD_END,
        CMD_PRINT,
        CMD_BELL
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [CHAR_W-1:0]   ch;
    } cmd_t;

    typedef struct packed {
        act_t                  action;
        logic [CHAR_W-1:0]     echo_char;
        logic [CNT_OUT_W-1:0]  erase_count;
        logic [CNT_OUT_W-1:0]  line_length;
    } result_t;

    typedef enum logic [1:0] {
        EX_IDLE,
        EX_WREAD,
        EX_WCHECK
    } ex_state_t;

endpackage

`default_nettype wire

// ===== hdl/terminal_line_editor.sv =====
// A byte accepted at one edge is stored in the command queue, then taken by the executor into
// the result register once the executor is idle and the result register is free or popped.
// Throughput: one byte per cycle while results are popped, for all codes but word-erase, which
// reads the line memory through one registered port, alternating a read and a check state per character.
// Reset clears the cursor, queues and result valid flag and loads the default codes;
// the line memory keeps whatever it held and is not cleared.
`default_nettype none

module terminal_line_editor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  in_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       action,
    output logic [6:0]       echo_char,
    output logic [6:0]       erase_count,
    output logic [6:0]       line_length,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    tle_pkg::cmd_t     fq_in;
    tle_pkg::cmd_t     fq_out;
    logic              fq_push;
    logic              fq_pop;
    logic              fq_empty;
    tle_pkg::result_t  res;
    logic              res_valid;

    tle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_byte   (in_byte),
        .q_full    (full),
        .q_data    (fq_in),
        .q_push    (fq_push),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tle_cmd_fifo u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fq_push),
        .push_data (fq_in),
        .full      (full),
        .pop       (fq_pop),
        .pop_data  (fq_out),
        .empty     (fq_empty)
    );

    tle_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (fq_out),
        .cmd_empty (fq_empty),
        .cmd_pop   (fq_pop),
        .res       (res),
        .res_valid (res_valid),
        .res_pop   (pop)
    );

    assign empty       = !res_valid;
    assign action      = res.action;
    assign echo_char   = res.echo_char;
    assign erase_count = res.erase_count;
    assign line_length = res.line_length;

endmodule

`default_nettype wire

// ===== hdl/tle_front.sv =====
// Front end of the line editor: holds the control-code registers and
// classifies each received byte into a command. Depends on tle_pkg.
`default_nettype none

module tle_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire logic [7:0]     in_byte,
    input  wire logic           q_full,
    output tle_pkg::cmd_t       q_data,
    output logic                q_push,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [7:0]     cfg_data
);

    logic [7:0] erase_code_reg;
    logic [7:0] kill_code_reg;
    logic [7:0] werase_code_reg;
    logic [7:0] end_code_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erase_code_reg  <= tle_pkg::ERASE_RESET;
            kill_code_reg   <= tle_pkg::KILL_RESET;
            werase_code_reg <= tle_pkg::WERASE_RESET;
            end_code_reg    <= tle_pkg::END_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tle_pkg::cfg_idx_t'(cfg_index))
                tle_pkg::CFG_ERASE:  erase_code_reg  <= cfg_data;
                tle_pkg::CFG_KILL:   kill_code_reg   <= cfg_data;
                tle_pkg::CFG_WERASE: werase_code_reg <= cfg_data;
                tle_pkg::CFG_END:    end_code_reg    <= cfg_data;
            endcase
        end
    end

    // Control codes are matched in fixed priority and win over the
    // printable test.
    always_comb
    begin
        q_data.ch = in_byte[tle_pkg::CHAR_W-1:0];
        priority if (in_byte == erase_code_reg)
            q_data.op = tle_pkg::CMD_ERASE;
        else if (in_byte == kill_code_reg)
            q_data.op = tle_pkg::CMD_KILL;
        else if (in_byte == werase_code_reg)
            q_data.op = tle_pkg::CMD_WERASE;
        else if (in_byte == end_code_reg)
            q_data.op = tle_pkg::CMD_END;
        else if (in_byte >= tle_pkg::PRINT_LOW && in_byte <= tle_pkg::PRINT_HIGH)
            q_data.op = tle_pkg::CMD_PRINT;
        else
            q_data.op = tle_pkg::CMD_BELL;
    end

    assign q_push = push && !q_full;

endmodule

`default_nettype wire

// ===== hdl/tle_cmd_fifo.sv =====
// Short command queue between the classifier and the line executor.
// Depends on tle_pkg for the command type and depth.
`default_nettype none

module tle_cmd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tle_pkg::cmd_t  push_data,
    output logic                full,
    input  wire logic           pop,
    output tle_pkg::cmd_t       pop_data,
    output logic                empty
);

    tle_pkg::cmd_t                    entry_reg [tle_pkg::CMDQ_DEPTH];
    logic [tle_pkg::CMDQ_PTR_W-1:0]   wr_ptr_reg;
    logic [tle_pkg::CMDQ_PTR_W-1:0]   rd_ptr_reg;
    logic [tle_pkg::CMDQ_CNT_W-1:0]   count_reg;
    logic [tle_pkg::CMDQ_CNT_W-1:0]   count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full     = (count_reg == tle_pkg::CMDQ_CNT_W'(tle_pkg::CMDQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== hdl/tle_exec.sv =====
// Back end of the line editor: owns the line memory and cursor, carries out
// one command at a time and holds the result register. Depends on tle_pkg.
`default_nettype none

module tle_exec (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tle_pkg::cmd_t  cmd,
    input  wire logic           cmd_empty,
    output logic                cmd_pop,
    output tle_pkg::result_t    res,
    output logic                res_valid,
    input  wire logic           res_pop
);

    localparam int CUR_W  = tle_pkg::CUR_W;
    localparam int ADDR_W = tle_pkg::ADDR_W;

    logic [tle_pkg::CHAR_W-1:0] line_mem [tle_pkg::LINE_MAX];
    logic [tle_pkg::CHAR_W-1:0] rd_data_reg;

    tle_pkg::ex_state_t  state_reg, state_next;
    logic [CUR_W-1:0]    cursor_reg, cursor_next;
    logic [CUR_W-1:0]    removed_reg, removed_next;
    logic                in_word_reg, in_word_next;
    tle_pkg::result_t    res_reg, res_next;
    logic                res_valid_reg, res_valid_next;

    logic [CUR_W-1:0]    cur_dec;
    logic [CUR_W-1:0]    cur_inc;
    logic                out_free;
    logic                rd_en;
    logic                wr_en;

    assign cur_dec   = cursor_reg - CUR_W'(1);
    assign cur_inc   = cursor_reg + CUR_W'(1);
    assign out_free  = !res_valid_reg || res_pop;
    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tle_pkg::EX_IDLE;
            cursor_reg    <= '0;
            removed_reg   <= '0;
            in_word_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            removed_reg   <= removed_next;
            in_word_reg   <= in_word_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (wr_en)
            line_mem[cursor_reg[ADDR_W-1:0]] <= cmd.ch;
        if (rd_en)
            rd_data_reg <= line_mem[cur_dec[ADDR_W-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        removed_next   = removed_reg;
        in_word_next   = in_word_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_pop;
        cmd_pop        = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;

        unique case (state_reg)
            tle_pkg::EX_IDLE:
            begin
                if (!cmd_empty && out_free)
                begin
                    cmd_pop                = 1'b1;
                    res_valid_next         = 1'b1;
                    res_next.action        = tle_pkg::ACT_BELL;
                    res_next.echo_char     = '0;
                    res_next.erase_count   = '0;
                    res_next.line_length   = tle_pkg::CNT_OUT_W'(cursor_reg);
                    unique case (cmd.op)
                        tle_pkg::CMD_ERASE:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next          = cur_dec;
                                res_next.action      = tle_pkg::ACT_ERASE;
                                res_next.erase_count = tle_pkg::CNT_OUT_W'(1);
                                res_next.line_length = tle_pkg::CNT_OUT_W'(cur_dec);
                            end
                        end
                        tle_pkg::CMD_KILL:
                        begin
                            cursor_next          = '0;
                            res_next.action      = tle_pkg::ACT_ERASE;
                            res_next.erase_count = tle_pkg::CNT_OUT_W'(cursor_reg);
                            res_next.line_length = '0;
                        end
                        tle_pkg::CMD_WERASE:
                        begin
                            // The result is written when the backward walk ends.
                            res_valid_next = 1'b0;
                            removed_next   = '0;
                            in_word_next   = 1'b0;
                            state_next     = tle_pkg::EX_WREAD;
                        end
                        tle_pkg::CMD_END:
                        begin
                            if (cursor_reg == '0)
                                res_next.action = tle_pkg::ACT_END;
                        end
                        tle_pkg::CMD_PRINT:
                        begin
                            if (cursor_reg != CUR_W'(tle_pkg::LINE_MAX))
                            begin
                                wr_en                = 1'b1;
                                cursor_next          = cur_inc;
                                res_next.action      = tle_pkg::ACT_ECHO;
                                res_next.echo_char   = cmd.ch;
                                res_next.line_length = tle_pkg::CNT_OUT_W'(cur_inc);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            tle_pkg::EX_WREAD:
            begin
                if (cursor_reg == '0)
                begin
                    res_valid_next       = 1'b1;
                    res_next.action      = tle_pkg::ACT_ERASE;
                    res_next.echo_char   = '0;
                    res_next.erase_count = tle_pkg::CNT_OUT_W'(removed_reg);
                    res_next.line_length = tle_pkg::CNT_OUT_W'(cursor_reg);
                    state_next           = tle_pkg::EX_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = tle_pkg::EX_WCHECK;
                end
            end

            tle_pkg::EX_WCHECK:
            begin
                // Trailing spaces go first; a space after the word part has
                // started marks the end of the walk.
                if (rd_data_reg == tle_pkg::SPACE_CHAR && in_word_reg)
                begin
                    res_valid_next       = 1'b1;
                    res_next.action      = tle_pkg::ACT_ERASE;
                    res_next.echo_char   = '0;
                    res_next.erase_count = tle_pkg::CNT_OUT_W'(removed_reg);
                    res_next.line_length = tle_pkg::CNT_OUT_W'(cursor_reg);
                    state_next           = tle_pkg::EX_IDLE;
                end
                else
                begin
                    if (rd_data_reg != tle_pkg::SPACE_CHAR)
                        in_word_next = 1'b1;
                    cursor_next  = cur_dec;
                    removed_next = removed_reg + CUR_W'(1);
                    state_next   = tle_pkg::EX_WREAD;
                end
            end

            default:
            begin
                state_next = tle_pkg::EX_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/tle_checker.sv =====
// Port-level checks for the terminal line editor, bound to its top level.
// Depends on tle_pkg for the action codes.
`default_nettype none

module tle_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pop,
    input wire logic        empty,
    input wire logic [1:0]  action,
    input wire logic [6:0]  echo_char,
    input wire logic [6:0]  erase_count,
    input wire logic [6:0]  line_length
);

    // Nothing is waiting right after reset is released.
    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result shown right after reset");

    // An echoed character always lands in the line.
    a_echo_grows_line: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && action == tle_pkg::ACT_ECHO) |->
            (erase_count == '0 && line_length != '0 && echo_char >= 7'd32))
        else $error("echo result with bad count or length");

    // Only an echo carries a character.
    a_char_only_on_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && action != tle_pkg::ACT_ECHO) |-> echo_char == '0)
        else $error("character on a non-echo result");

    // Bell and end of input erase nothing; end of input leaves an empty line.
    a_bell_end_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (action == tle_pkg::ACT_BELL || action == tle_pkg::ACT_END)) |->
            (erase_count == '0 && (action == tle_pkg::ACT_BELL || line_length == '0)))
        else $error("bell or end result with bad counts");

    // A result that is not taken stays as it is.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(action) && $stable(erase_count)
            && $stable(line_length)))
        else $error("waiting result changed");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (.*);

`default_nettype wire

// ===== tb/terminal_line_editor_tb.sv =====
// Self-checking testbench for terminal_line_editor: a directed table, then random typing
// sessions under several erase/kill/word-erase/end code settings, checked by a line predictor.
// Depends on tle_pkg and the terminal_line_editor RTL only.
`default_nettype none

module terminal_line_editor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEYS_PER_PHASE  = 170;
    localparam int NUM_PHASES      = 6;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int TAIL_CYCLES     = 2 * tle_pkg::LINE_MAX + 8;
    localparam logic [7:0] SPACE_KEY = {1'b0, tle_pkg::SPACE_CHAR};

    typedef struct packed {
        logic [7:0]       key;
        tle_pkg::result_t resp;
    } key_resp_t;

    typedef struct packed {
        logic [7:0]       key;
        logic             typed;
        tle_pkg::result_t resp;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] in_byte = 8'd0;
    logic       empty;
    logic       pop = 1'b0;
    logic [1:0] action;
    logic [6:0] echo_char;
    logic [6:0] erase_count;
    logic [6:0] line_length;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = tle_pkg::CFG_ERASE;
    logic [7:0] cfg_data = 8'd0;

    // Predictor state: the typed line, its length and the active control codes.
    logic [tle_pkg::CHAR_W-1:0] line_buf [tle_pkg::LINE_MAX];
    int                         cursor_pos = 0;
    logic [7:0]                 codes [4] = '{tle_pkg::ERASE_RESET, tle_pkg::KILL_RESET,
                                              tle_pkg::WERASE_RESET, tle_pkg::END_RESET};

    key_resp_t term_resp_q [$];
    int        fail_count = 0;
    int        keys_sent = 0;
    int        stalled_cycles = 0;
    bit        no_idle = 1'b0;

    // Control codes in the order erase, kill, word-erase, end: backspace-style, extremes, full
    // collisions, codes inside the printable range, paired reset codes, then the reset codes.
    logic [7:0] phase_codes [NUM_PHASES][4] = '{
        '{8'd8,   8'd0,   8'd255, 8'd26},
        '{8'd255, 8'd127, 8'd0,   8'd1},
        '{8'd32,  8'd32,  8'd32,  8'd32},
        '{8'd65,  8'd66,  8'd67,  8'd68},
        '{8'd21,  8'd21,  8'd4,   8'd4},
        '{8'd127, 8'd21,  8'd23,  8'd4}
    };

    dir_row_t dir_rows [25] = '{
        '{8'd127, 1'b1, '{tle_pkg::ACT_BELL,  7'd0,   7'd0, 7'd0}},
        '{8'd21,  1'b1, '{tle_pkg::ACT_ERASE, 7'd0,   7'd0, 7'd0}},
        '{8'd23,  1'b1, '{tle_pkg::ACT_ERASE, 7'd0,   7'd0, 7'd0}},
        '{8'd4,   1'b1, '{tle_pkg::ACT_END,   7'd0,   7'd0, 7'd0}},
        '{8'd0,   1'b1, '{tle_pkg::ACT_BELL,  7'd0,   7'd0, 7'd0}},
        '{8'd255, 1'b1, '{tle_pkg::ACT_BELL,  7'd0,   7'd0, 7'd0}},
        '{8'd31,  1'b1, '{tle_pkg::ACT_BELL,  7'd0,   7'd0, 7'd0}},
        '{8'd128, 1'b1, '{tle_pkg::ACT_BELL,  7'd0,   7'd0, 7'd0}},
        '{8'd32,  1'b1, '{tle_pkg::ACT_ECHO,  7'd32,  7'd0, 7'd1}},
        '{8'd126, 1'b1, '{tle_pkg::ACT_ECHO,  7'd126, 7'd0, 7'd2}},
        '{8'd127, 1'b1, '{tle_pkg::ACT_ERASE, 7'd0,   7'd1, 7'd1}},
        '{8'd21,  1'b1, '{tle_pkg::ACT_ERASE, 7'd0,   7'd1, 7'd0}},
        '{8'd104, 1'b0, '{tle_pkg::ACT_ECHO,  7'd0,   7'd0, 7'd0}},
        '{8'd105, 1'b0, '{tle_pkg::ACT_ECHO,  7'd0,   7'd0, 7'd0}},
        '{8'd32,  1'b0, '{tle_pkg::ACT_ECHO,  7'd0,   7'd0, 7'd0}},
        '{8'd32,  1'b0, '{tle_pkg::ACT_ECHO,  7'd0,   7'd0, 7'd0}},
        '{8'd121, 1'b0, '{tle_pkg::ACT_ECHO,  7'd0,   7'd0, 7'd0}},
        '{8'd111, 1'b0, '{tle_pkg::ACT_ECHO,  7'd0,   7'd0, 7'd0}},
        '{8'd4,   1'b0, '{tle_pkg::ACT_ECHO,  7'd0,   7'd0, 7'd0}},
        '{8'd23,  1'b0, '{tle_pkg::ACT_ECHO,  7'd0,   7'd0, 7'd0}},
        '{8'd23,  1'b0, '{tle_pkg::ACT_ECHO,  7'd0,   7'd0, 7'd0}},
        '{8'd4,   1'b1, '{tle_pkg::ACT_END,   7'd0,   7'd0, 7'd0}},
        '{8'd122, 1'b0, '{tle_pkg::ACT_ECHO,  7'd0,   7'd0, 7'd0}},
        '{8'd65,  1'b0, '{tle_pkg::ACT_ECHO,  7'd0,   7'd0, 7'd0}},
        '{8'd21,  1'b0, '{tle_pkg::ACT_ECHO,  7'd0,   7'd0, 7'd0}}
    };

    terminal_line_editor u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .empty       (empty),
        .pop         (pop),
        .action      (action),
        .echo_char   (echo_char),
        .erase_count (erase_count),
        .line_length (line_length),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Applies one keystroke to the predicted line and returns the terminal response.
    function automatic tle_pkg::result_t edit_line(input logic [7:0] b);
        tle_pkg::result_t r;
        int               removed;
        r = '{tle_pkg::ACT_BELL, 7'd0, 7'd0, 7'd0};
        removed = 0;
        if (b == codes[tle_pkg::CFG_ERASE])
        begin
            if (cursor_pos > 0)
            begin
                cursor_pos--;
                r.action = tle_pkg::ACT_ERASE;
                r.erase_count = 7'd1;
            end
        end
        else if (b == codes[tle_pkg::CFG_KILL])
        begin
            r.action = tle_pkg::ACT_ERASE;
            r.erase_count = 7'(cursor_pos);
            cursor_pos = 0;
        end
        else if (b == codes[tle_pkg::CFG_WERASE])
        begin
            // Trailing blanks go first, then the word in front of them.
            while (cursor_pos > 0 && line_buf[cursor_pos-1] == tle_pkg::SPACE_CHAR)
            begin
                cursor_pos--;
                removed++;
            end
            while (cursor_pos > 0 && line_buf[cursor_pos-1] != tle_pkg::SPACE_CHAR)
            begin
                cursor_pos--;
                removed++;
            end
            r.action = tle_pkg::ACT_ERASE;
            r.erase_count = 7'(removed);
        end
        else if (b == codes[tle_pkg::CFG_END])
        begin
            if (cursor_pos == 0)
                r.action = tle_pkg::ACT_END;
        end
        else if (b >= tle_pkg::PRINT_LOW && b <= tle_pkg::PRINT_HIGH
                 && cursor_pos < tle_pkg::LINE_MAX)
        begin
            line_buf[cursor_pos] = b[tle_pkg::CHAR_W-1:0];
            cursor_pos++;
            r.action = tle_pkg::ACT_ECHO;
            r.echo_char = b[tle_pkg::CHAR_W-1:0];
        end
        r.line_length = 7'(cursor_pos);
        return r;
    endfunction

    // Pushes one keystroke after a random gap; push is left high on return.
    task automatic type_key(input logic [7:0] b, input logic typed = 1'b0,
                            input tle_pkg::result_t fixed = '0);
        int               gap;
        tle_pkg::result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        in_byte <= b;
        do @(posedge clk); while (full);
        predicted = edit_line(b);
        term_resp_q.push_back('{b, typed ? fixed : predicted});
        keys_sent++;
    endtask

    task automatic drain_responses();
        push <= 1'b0;
        do @(posedge clk); while (term_resp_q.size() != 0);
    endtask

    initial
    begin
        int         p;
        int         i;
        int         n;
        int         w;
        int         len;
        int         target;
        logic [7:0] c;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part runs with the codes left by reset.
        for (i = 0; i < $size(dir_rows); i++)
            type_key(dir_rows[i].key, dir_rows[i].typed, dir_rows[i].resp);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            // Codes change only once every response of the previous phase is in.
            drain_responses();
            cfg_valid <= 1'b1;
            for (i = 0; i < 4; i++)
            begin
                cfg_index <= tle_pkg::cfg_idx_t'(i);
                cfg_data <= phase_codes[p][i];
                do @(posedge clk); while (!cfg_ready);
                codes[i] = phase_codes[p][i];
            end
            cfg_valid <= 1'b0;

            target = keys_sent + KEYS_PER_PHASE;
            while (keys_sent < target)
            begin
                no_idle = ($urandom_range(0, 4) == 0);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        n = $urandom_range(1, 6);
                        for (w = 0; w < n; w++)
                        begin
                            len = $urandom_range(1, 8);
                            for (i = 0; i < len; i++)
                            begin
                                type_key(8'($urandom_range(33, 126)));
                                if ($urandom_range(0, 9) == 0)
                                    type_key(codes[tle_pkg::CFG_ERASE]);
                            end
                            repeat ($urandom_range(1, 2)) type_key(SPACE_KEY);
                        end
                        // Some lines are left open so that later sessions fill them up.
                        case ($urandom_range(0, 3))
                            0: repeat ($urandom_range(1, 3)) type_key(codes[tle_pkg::CFG_WERASE]);
                            1: type_key(codes[tle_pkg::CFG_KILL]);
                            2:
                            begin
                                type_key(codes[tle_pkg::CFG_END]);
                                type_key(codes[tle_pkg::CFG_KILL]);
                                type_key(codes[tle_pkg::CFG_END]);
                            end
                            default: ;
                        endcase
                    end
                    6:
                    begin
                        // Types up to or past a full line, then backs out of it.
                        len = $urandom_range(60, 72);
                        for (i = 0; i < len; i++)
                        begin
                            c = ($urandom_range(0, 5) == 0) ? SPACE_KEY
                                                            : 8'($urandom_range(33, 126));
                            type_key(c);
                        end
                        repeat ($urandom_range(1, 3)) type_key(codes[tle_pkg::CFG_WERASE]);
                        type_key(codes[tle_pkg::CFG_ERASE]);
                        type_key(codes[tle_pkg::CFG_KILL]);
                    end
                    default:
                        repeat ($urandom_range(1, 8)) type_key(8'($urandom_range(0, 255)));
                endcase
            end
        end

        drain_responses();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && term_resp_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Response side: random pop stalls, each response checked against the oldest prediction.
    initial
    begin
        int        stall;
        key_resp_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            if (term_resp_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected response: act %0d echo %0d erase %0d len %0d",
                             action, echo_char, erase_count, line_length);
            end
            else
            begin
                want = term_resp_q.pop_front();
                if (action !== want.resp.action || echo_char !== want.resp.echo_char ||
                    erase_count !== want.resp.erase_count ||
                    line_length !== want.resp.line_length)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch on key 0x%02h: expected act %0d echo %0d ",
                                 want.key, want.resp.action, want.resp.echo_char,
                                 "erase %0d len %0d, got act %0d echo %0d erase %0d len %0d",
                                 want.resp.erase_count, want.resp.line_length,
                                 action, echo_char, erase_count, line_length);
                end
            end
        end
    end

    // Any transaction on any channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_CYCLES)
        begin
            $display("watchdog: no transaction for %0d cycles", stalled_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

`default_nettype wire
